/* rtl/core/rhws_pkg.sv */
`default_nettype none

package rhws_pkg;

	localparam int ITER_IDX_W = 5;
	localparam int CORDIC_W   = 34;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] CFG_LEFT_BIAS  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_RIGHT_BIAS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_VELOCITY   = 2'd2;

	localparam logic [CFG_DATA_W-1:0] VELOCITY_RST = 16'd256;

	localparam logic signed [CORDIC_W-1:0] CORDIC_START = 34'sd652032874;

	typedef struct packed {
		logic                  start;
		logic                  iter;
		logic [ITER_IDX_W-1:0] iter_idx;
		logic                  mul_x;
		logic                  mul_y;
		logic                  upd_y;
		logic                  load_out;
	} dp_cmd_t;

	function automatic logic [29:0] atan_val(input logic [ITER_IDX_W-1:0] idx);
		logic [29:0] v;
		case (idx)
			5'd0:    v = 30'd536870912;
			5'd1:    v = 30'd316933406;
			5'd2:    v = 30'd167458907;
			5'd3:    v = 30'd85004756;
			5'd4:    v = 30'd42667331;
			5'd5:    v = 30'd21354465;
			5'd6:    v = 30'd10679838;
			5'd7:    v = 30'd5340245;
			5'd8:    v = 30'd2670163;
			5'd9:    v = 30'd1335087;
			5'd10:   v = 30'd667544;
			5'd11:   v = 30'd333772;
			5'd12:   v = 30'd166886;
			5'd13:   v = 30'd83443;
			5'd14:   v = 30'd41722;
			5'd15:   v = 30'd20861;
			5'd16:   v = 30'd10430;
			5'd17:   v = 30'd5215;
			5'd18:   v = 30'd2608;
			5'd19:   v = 30'd1304;
			5'd20:   v = 30'd652;
			5'd21:   v = 30'd326;
			5'd22:   v = 30'd163;
			5'd23:   v = 30'd81;
			default: v = 30'd0;
		endcase
		return v;
	endfunction

endpackage

`default_nettype wire

/* rtl/core/rhws_ctrl.sv */
`default_nettype none

module rhws_ctrl
	import rhws_pkg::*;
#(
	parameter int CORDIC_ITERS = 16
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    in_valid,
	output logic         in_ready,
	output logic         out_valid,
	input  wire logic    out_ready,
	output dp_cmd_t      cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_ITER,
		S_MULX,
		S_MULY,
		S_UPDY,
		S_HOLD
	} state_t;

	localparam logic [ITER_IDX_W-1:0] LAST_ITER = ITER_IDX_W'(CORDIC_ITERS - 1);

	state_t                state_q;
	logic [ITER_IDX_W-1:0] cnt_q;
	logic                  out_valid_q;
	logic                  load_out;

	assign load_out  = (state_q == S_HOLD) && (!out_valid_q || out_ready);
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd.start    = (state_q == S_IDLE) && in_valid;
		cmd.iter     = (state_q == S_ITER);
		cmd.iter_idx = cnt_q;
		cmd.mul_x    = (state_q == S_MULX);
		cmd.mul_y    = (state_q == S_MULY);
		cmd.upd_y    = (state_q == S_UPDY);
		cmd.load_out = load_out;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						cnt_q   <= '0;
						state_q <= S_ITER;
					end
				end
				S_ITER: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == LAST_ITER) begin
						state_q <= S_MULX;
					end
				end
				S_MULX: state_q <= S_MULY;
				S_MULY: state_q <= S_UPDY;
				S_UPDY: state_q <= S_HOLD;
				S_HOLD: begin
					if (load_out) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

/* rtl/core/rhws_dp.sv */
`default_nettype none

module rhws_dp
	import rhws_pkg::*;
#(
	parameter int ANGLE_BITS = 16,
	parameter int POS_BITS   = 32
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cfg_we,
	input  wire logic [CFG_IDX_W-1:0]         cfg_index,
	input  wire logic [CFG_DATA_W-1:0]        cfg_data,
	input  wire logic [15:0]                  random_fraction,
	input  wire dp_cmd_t                      cmd,
	output logic      [ANGLE_BITS-1:0]        heading,
	output logic signed [POS_BITS-1:0]        pos_x,
	output logic signed [POS_BITS-1:0]        pos_y
);

	localparam int TW    = ((ANGLE_BITS > 17) ? ANGLE_BITS : 17) + 1;
	localparam int PW    = 49;
	localparam int DW    = PW - 22;
	localparam int SW    = ((POS_BITS > DW) ? POS_BITS : DW) + 1;
	localparam logic signed [PW-1:0] ROUND_HALF = PW'(1) << 21;
	localparam logic signed [SW-1:0] POS_HI = {{(SW-POS_BITS+1){1'b0}}, {(POS_BITS-1){1'b1}}};
	localparam logic signed [SW-1:0] POS_LO = {{(SW-POS_BITS+1){1'b1}}, {(POS_BITS-1){1'b0}}};

	logic [15:0] left_bias_q;
	logic [15:0] right_bias_q;
	logic [15:0] velocity_q;

	logic        [ANGLE_BITS-1:0] heading_q;
	logic signed [POS_BITS-1:0]   x_q;
	logic signed [POS_BITS-1:0]   y_q;

	logic signed [CORDIC_W-1:0] cx_q;
	logic signed [CORDIC_W-1:0] cy_q;
	logic signed [CORDIC_W-1:0] z_q;
	logic                       flip_q;
	logic signed [PW-1:0]       prod_q;

	logic [16:0]           span;
	logic [32:0]           tprod;
	logic [TW-1:0]         newh_w;
	logic [ANGLE_BITS-1:0] newh;
	logic [31:0]           a32;
	logic                  flip_n;
	logic [31:0]           zang;

	logic signed [CORDIC_W-1:0] xs;
	logic signed [CORDIC_W-1:0] ys;
	logic signed [CORDIC_W-1:0] at;

	logic signed [CORDIC_W-1:0] mop_src;
	logic signed [CORDIC_W-1:0] mop;
	logic signed [16:0]         mul_a;
	logic signed [31:0]         mul_b;
	logic signed [PW-1:0]       prod_n;

	logic signed [PW-1:0]       rnd;
	logic signed [DW-1:0]       delta;
	logic signed [POS_BITS-1:0] pos_src;
	logic signed [SW-1:0]       sum;
	logic signed [POS_BITS-1:0] sat_n;

	// turn and new heading
	always_comb begin
		span   = {1'b0, left_bias_q} + {1'b0, right_bias_q};
		tprod  = random_fraction * span;
		newh_w = TW'(heading_q) + TW'(tprod[32:16]) - TW'(left_bias_q);
		newh   = newh_w[ANGLE_BITS-1:0];
		a32    = {newh, {(32-ANGLE_BITS){1'b0}}};
		flip_n = a32[31] ^ a32[30];
		zang   = {a32[31] ^ flip_n, a32[30:0]};
	end

	// one cordic micro-rotation
	always_comb begin
		xs = cx_q >>> cmd.iter_idx;
		ys = cy_q >>> cmd.iter_idx;
		at = $signed({4'b0000, atan_val(cmd.iter_idx)});
	end

	// shared multiplier
	always_comb begin
		mop_src = cmd.mul_y ? cy_q : cx_q;
		mop     = flip_q ? -mop_src : mop_src;
		mul_a   = $signed({1'b0, velocity_q});
		mul_b   = mop[31:0];
		prod_n  = mul_a * mul_b;
	end

	// round, add and saturate
	always_comb begin
		rnd     = prod_q + ROUND_HALF;
		delta   = rnd[PW-1:22];
		pos_src = cmd.upd_y ? y_q : x_q;
		sum     = SW'(pos_src) + SW'(delta);
		if (sum > POS_HI) begin
			sat_n = POS_HI[POS_BITS-1:0];
		end else if (sum < POS_LO) begin
			sat_n = POS_LO[POS_BITS-1:0];
		end else begin
			sat_n = sum[POS_BITS-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_bias_q  <= '0;
			right_bias_q <= '0;
			velocity_q   <= VELOCITY_RST;
			heading_q    <= '0;
			x_q          <= '0;
			y_q          <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_LEFT_BIAS:  left_bias_q  <= cfg_data;
					CFG_RIGHT_BIAS: right_bias_q <= cfg_data;
					CFG_VELOCITY:   velocity_q   <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.start) begin
				heading_q <= newh;
			end
			if (cmd.mul_y) begin
				x_q <= sat_n;
			end
			if (cmd.upd_y) begin
				y_q <= sat_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			cx_q   <= CORDIC_START;
			cy_q   <= '0;
			z_q    <= {{(CORDIC_W-32){zang[31]}}, zang};
			flip_q <= flip_n;
		end else if (cmd.iter) begin
			if (!z_q[CORDIC_W-1]) begin
				cx_q <= cx_q - ys;
				cy_q <= cy_q + xs;
				z_q  <= z_q - at;
			end else begin
				cx_q <= cx_q + ys;
				cy_q <= cy_q - xs;
				z_q  <= z_q + at;
			end
		end
		if (cmd.mul_x || cmd.mul_y) begin
			prod_q <= prod_n;
		end
		if (cmd.load_out) begin
			heading <= heading_q;
			pos_x   <= x_q;
			pos_y   <= y_q;
		end
	end

endmodule

`default_nettype wire

/* rtl/core/random_heading_walk_step.sv */
//  channel   direction  handshake                 payload
//  cfg       in         cfg_we                    cfg_index, cfg_data
//  request   in         in_valid / in_ready       random_fraction
//  result    out        out_valid / out_ready     heading, pos_x, pos_y
//
//  one request runs through the iter, mulx, muly and updy states and its result is
//  loaded from the hold state, using the single shared cordic stage and multiplier
//  in_ready is high only while the controller is idle, so a new request is not
//  taken until the result of the previous one has been loaded
//  a result waiting on out_ready lets the next request in but holds its result back
//  arst_n clears heading, position and the registers (velocity to 1.0)
`default_nettype none

module random_heading_walk_step
	import rhws_pkg::*;
#(
	parameter int ANGLE_BITS   = 16,
	parameter int POS_BITS     = 32,
	parameter int CORDIC_ITERS = 16
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_we,
	input  wire logic [CFG_IDX_W-1:0]        cfg_index,
	input  wire logic [CFG_DATA_W-1:0]       cfg_data,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire logic [15:0]                 random_fraction,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output logic      [ANGLE_BITS-1:0]       heading,
	output logic signed [POS_BITS-1:0]       pos_x,
	output logic signed [POS_BITS-1:0]       pos_y
);

	dp_cmd_t cmd;

	rhws_ctrl #(
		.CORDIC_ITERS(CORDIC_ITERS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	rhws_dp #(
		.ANGLE_BITS(ANGLE_BITS),
		.POS_BITS  (POS_BITS)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.random_fraction (random_fraction),
		.cmd             (cmd),
		.heading         (heading),
		.pos_x           (pos_x),
		.pos_y           (pos_y)
	);

endmodule

`default_nettype wire

/* rtl/core/rhws_chk.sv */
`default_nettype none

module rhws_chk #(
	parameter int ANGLE_BITS = 16,
	parameter int POS_BITS   = 32
) (
	input wire logic                  clk,
	input wire logic                  arst_n,
	input wire logic                  in_valid,
	input wire logic                  in_ready,
	input wire logic                  out_valid,
	input wire logic                  out_ready,
	input wire logic [ANGLE_BITS-1:0] heading,
	input wire logic [POS_BITS-1:0]   pos_x,
	input wire logic [POS_BITS-1:0]   pos_y
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=>
			out_valid && $stable(heading) && $stable(pos_x) && $stable(pos_y))
		else $error("result changed while stalled");

	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request taken while busy");

	a_no_instant_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !$rose(out_valid))
		else $error("result appeared too early");

	a_idle_stays: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready && !in_valid |=> in_ready)
		else $error("left idle without a request");

endmodule

bind random_heading_walk_step rhws_chk #(
	.ANGLE_BITS(ANGLE_BITS),
	.POS_BITS  (POS_BITS)
) u_rhws_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.heading   (heading),
	.pos_x     (pos_x),
	.pos_y     (pos_y)
);

`default_nettype wire

/* bench/random_heading_walk_step_tb.sv */
`timescale 1ns / 1ps

module random_heading_walk_step_tb;
	import rhws_pkg::*;

	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
	localparam longint POS_MAX = 64'sd2147483647;
	localparam longint POS_MIN = -POS_MAX - 1;
	localparam longint GAIN_START = 64'sd652032874;
	localparam logic [29:0] ATAN_TAB [0:15] = '{
		30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756,
		30'd42667331, 30'd21354465, 30'd10679838, 30'd5340245,
		30'd2670163, 30'd1335087, 30'd667544, 30'd333772,
		30'd166886, 30'd83443, 30'd41722, 30'd20861
	};

	typedef struct {
		logic [15:0]        heading;
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
	} walk_point_t;

	class walk_scoreboard;
		logic [15:0] left_bias;
		logic [15:0] right_bias;
		logic [15:0] velocity;
		logic [15:0] head;
		longint px;
		longint py;
		walk_point_t expected_q[$];
		int errors;
		int requests;
		int results;

		function new();
			left_bias = '0;
			right_bias = '0;
			velocity = VELOCITY_RST;
			head = '0;
			px = 0;
			py = 0;
			errors = 0;
			requests = 0;
			results = 0;
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
			case (idx)
				CFG_LEFT_BIAS: left_bias = val;
				CFG_RIGHT_BIAS: right_bias = val;
				CFG_VELOCITY: velocity = val;
				default: ;
			endcase
		endfunction

		function longint clamp(longint v);
			if (v > POS_MAX)
				return POS_MAX;
			if (v < POS_MIN)
				return POS_MIN;
			return v;
		endfunction

		// fixed-length rotation, half-turn fold for the left half plane
		function void sin_cos(input logic [15:0] h, output longint c, output longint s);
			logic [31:0] a;
			logic fold;
			longint cx, cy, z, xs, ys;
			int i;
			a = {h, 16'h0000};
			fold = (a[31:30] == 2'b01) || (a[31:30] == 2'b10);
			if (fold)
				a = a + 32'h8000_0000;
			z = $signed(a);
			cx = GAIN_START;
			cy = 0;
			for (i = 0; i < 16; i++) begin
				xs = cx >>> i;
				ys = cy >>> i;
				if (z >= 0) begin
					cx = cx - ys;
					cy = cy + xs;
					z = z - longint'(ATAN_TAB[i]);
				end else begin
					cx = cx + ys;
					cy = cy - xs;
					z = z + longint'(ATAN_TAB[i]);
				end
			end
			if (fold) begin
				cx = -cx;
				cy = -cy;
			end
			c = cx;
			s = cy;
		endfunction

		function void note_request(logic [15:0] r);
			longint rv, lb, rb, hv, vel, t, c, s, dx, dy;
			walk_point_t p;
			rv = r;
			lb = left_bias;
			rb = right_bias;
			hv = head;
			vel = velocity;
			t = hv + ((rv * (lb + rb)) >>> 16) - lb;
			head = t[15:0];
			sin_cos(head, c, s);
			dx = (vel * c + 64'sd2097152) >>> 22;
			dy = (vel * s + 64'sd2097152) >>> 22;
			px = clamp(px + dx);
			py = clamp(py + dy);
			p.heading = head;
			p.pos_x = px[31:0];
			p.pos_y = py[31:0];
			expected_q.push_back(p);
			requests++;
		endfunction

		function void check_result(logic [15:0] h, logic signed [31:0] x, logic signed [31:0] y);
			walk_point_t p;
			results++;
			if (expected_q.size() == 0) begin
				$error("result with no request pending: heading %0d pos_x %0d pos_y %0d",
					h, x, y);
				errors++;
				return;
			end
			p = expected_q.pop_front();
			if (h !== p.heading) begin
				$error("heading: expected %0d, got %0d", p.heading, h);
				errors++;
			end
			if (x !== p.pos_x) begin
				$error("pos_x: expected %0d, got %0d", p.pos_x, x);
				errors++;
			end
			if (y !== p.pos_y) begin
				$error("pos_y: expected %0d, got %0d", p.pos_y, y);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [15:0] random_fraction = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [15:0] heading;
	logic signed [31:0] pos_x;
	logic signed [31:0] pos_y;

	int gap_pct = 0;
	int stall_pct = 0;
	int settings = 0;
	walk_scoreboard sb;

	random_heading_walk_step uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.random_fraction(random_fraction),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.heading(heading),
		.pos_x(pos_x),
		.pos_y(pos_y)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#4_000_000;
		$display("TEST FAILED");
		$finish;
	end

	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_we)
				sb.write_reg(cfg_index, cfg_data);
			if (in_valid && in_ready)
				sb.note_request(random_fraction);
			if (out_valid && out_ready)
				sb.check_result(heading, pos_x, pos_y);
		end
	end

	task automatic send_request(input logic [15:0] r);
		while ($urandom_range(99) < gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		random_fraction <= r;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
	endtask

	task automatic set_regs(input logic [15:0] lb, input logic [15:0] rb, input logic [15:0] vel);
		drain();
		repeat (4) @(posedge clk);
		write_reg(CFG_LEFT_BIAS, lb);
		write_reg(CFG_RIGHT_BIAS, rb);
		write_reg(CFG_VELOCITY, vel);
		cfg_we <= 1'b0;
		settings++;
	endtask

	task automatic run_phase(input int gap, input int stall, input int count,
			input logic [15:0] lb, input logic [15:0] rb, input logic [15:0] vel);
		logic [15:0] r;
		int pick;
		int k;
		set_regs(lb, rb, vel);
		gap_pct = gap;
		stall_pct = stall;
		for (k = 0; k < count; k++) begin
			pick = $urandom_range(9);
			if (pick == 0)
				r = 16'h0000;
			else if (pick == 1)
				r = 16'hFFFF;
			else
				r = 16'($urandom);
			send_request(r);
			// hold off until the walk has caught up
			if (gap != 0 && k % 25 == 24)
				drain();
		end
	endtask

	initial begin
		sb = new();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// defaults after reset: no turn, unit speed
		send_request(16'h0000);
		send_request(16'hFFFF);

		// full half-turn either way
		set_regs(16'd32768, 16'd32768, 16'd256);
		send_request(16'h0000);
		send_request(16'hFFFF);
		send_request(16'h8000);
		send_request(16'h0001);
		send_request(16'hFFFE);
		send_request(16'h5555);
		send_request(16'hAAAA);

		// straight line at top speed
		set_regs(16'd0, 16'd0, 16'hFFFF);
		send_request(16'hFFFF);
		send_request(16'h0000);

		// right turns only, standing still
		set_regs(16'd0, 16'd32768, 16'd0);
		send_request(16'hFFFF);
		send_request(16'h8000);

		// left turns only, smallest speed, then an unmapped register index
		set_regs(16'd32768, 16'd0, 16'd1);
		@(posedge clk);
		write_reg(CFG_UNUSED, 16'hFFFF);
		cfg_we <= 1'b0;
		send_request(16'h0000);
		send_request(16'hFFFF);
		send_request(16'h1234);
		send_request(16'hEDCB);

		run_phase(0, 0, 45, 16'd1000, 16'd3000, 16'd256);
		run_phase(72, 0, 45, 16'($urandom_range(32768)), 16'($urandom_range(32768)),
			16'($urandom));
		run_phase(0, 72, 45, 16'd32768, 16'd32768, 16'hFFFF);
		// long straight run into the position limits
		run_phase(9, 9, 180, 16'd0, 16'd0, 16'hFFFF);

		// exact about-turn with the position frozen, then back off the limit
		set_regs(16'd32768, 16'd0, 16'd0);
		gap_pct = 0;
		stall_pct = 0;
		send_request(16'h0000);
		run_phase(72, 0, 80, 16'd0, 16'd0, 16'hFFFF);
		run_phase(0, 72, 40, 16'($urandom_range(32768)), 16'($urandom_range(32768)),
			16'($urandom));

		drain();
		repeat (40) @(posedge clk);
		$display("%0d requests and %0d results checked over %0d register settings",
			sb.requests, sb.results, settings);
		$display("turn and speed extremes, saturating runs and an unmapped register index");
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

/* random_heading_walk_step.f */
rtl/core/rhws_pkg.sv
rtl/core/rhws_ctrl.sv
rtl/core/rhws_dp.sv
rtl/core/random_heading_walk_step.sv
rtl/core/rhws_chk.sv
bench/random_heading_walk_step_tb.sv
